>>> src/cubic_hermite_interpolator_top_defines.svh
// Assertion helpers used by the top module of this block.
`ifndef CUBIC_HERMITE_INTERPOLATOR_TOP_DEFINES_SVH
`define CUBIC_HERMITE_INTERPOLATOR_TOP_DEFINES_SVH

// Checks that an antecedent implies a consequent in the same cycle.
`define CHI_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that an antecedent implies a consequent in the next cycle.
`define CHI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/chi_pkg.sv
package chi_pkg;

  localparam int FracBits = 16;
  localparam int QuoBits = 32 + FracBits;
  localparam int DivCells = QuoBits + 1;

  localparam logic signed [63:0] QMax = 64'sd2147483647;
  localparam logic signed [63:0] QMin = -64'sd2147483648;

  // Data handed from one cell of the chain to the next.
  typedef struct packed {
    logic               live;
    logic               degen;
    logic               neg;
    logic [QuoBits-1:0] num;
    logic [QuoBits-1:0] quo;
    logic [32:0]        rem;
    logic [31:0]        den;
    logic signed [31:0] va;
    logic signed [31:0] vb;
    logic signed [32:0] dt;
    logic signed [31:0] s1;
    logic signed [31:0] s2;
    logic signed [31:0] c3;
    logic signed [31:0] c2;
    logic signed [31:0] x;
    logic signed [31:0] acc;
    logic               sat;
  } chi_token_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v,
                                               output logic flag);
    flag = 1'b0;
    if (v > QMax) begin
      flag = 1'b1;
      sat32 = 32'sh7fffffff;
    end else if (v < QMin) begin
      flag = 1'b1;
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  // Q product rounded to nearest, ties up; arithmetic shift floors.
  function automatic logic signed [63:0] qmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    p = p + (64'sd1 <<< (FracBits - 1));
    qmul = p >>> FracBits;
  endfunction

endpackage

>>> src/chi_div_cell.sv
module chi_div_cell (
  input  logic               clk,
  input  logic               rst,
  input  chi_pkg::chi_token_t in_tok,
  output chi_pkg::chi_token_t out_tok
);
  import chi_pkg::*;

  logic [32:0] part;
  logic [33:0] diff;
  chi_token_t  nxt;

  // One restoring division step: bring in the next numerator bit.
  always_comb begin
    nxt = in_tok;
    part = {in_tok.rem[31:0], in_tok.num[QuoBits-1]};
    diff = {1'b0, part} - {2'b00, in_tok.den};
    nxt.num = {in_tok.num[QuoBits-2:0], 1'b0};
    if (!diff[33]) begin
      nxt.rem = diff[32:0];
      nxt.quo = {in_tok.quo[QuoBits-2:0], 1'b1};
    end else begin
      nxt.rem = part;
      nxt.quo = {in_tok.quo[QuoBits-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_tok <= '0;
    end else begin
      out_tok <= nxt;
    end
  end

endmodule

>>> src/chi_horner_cell.sv
module chi_horner_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          sel,
  input  chi_pkg::chi_token_t in_tok,
  output chi_pkg::chi_token_t out_tok
);
  import chi_pkg::*;

  logic signed [63:0] prod;
  logic signed [31:0] addend;
  logic signed [31:0] sum;
  logic               f;
  chi_token_t         nxt;

  // prod is registered first, then added, as two halves of the cell.
  chi_token_t mid;
  logic signed [63:0] prod_q;

  always_comb begin
    prod = qmul(in_tok.acc, in_tok.x);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid <= '0;
      prod_q <= '0;
    end else begin
      mid <= in_tok;
      prod_q <= prod;
    end
  end

  always_comb begin
    case (sel)
      2'd0:    addend = mid.c2;
      2'd1:    addend = mid.s1;
      default: addend = mid.va;
    endcase
    nxt = mid;
    sum = sat32(prod_q + 64'(addend), f);
    nxt.acc = sum;
    nxt.sat = mid.sat | f;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_tok <= '0;
    end else begin
      out_tok <= nxt;
    end
  end

endmodule

>>> src/cubic_hermite_interpolator_top.sv
// Cubic Hermite interpolator. One item (two knots and a query time) may be
// started in every clock cycle; busy is held low, so start is never refused.
// Each item yields exactly one result, shown for one cycle with done high.
// The item passes through 57 register stages: one input register, 48
// cells of a long-division chain that forms the normalized position, a
// slope-scaling register, a coefficient register, and three Horner cells,
// each a product register and a sum register. The receiver cannot stall
// the output, so it must take every result in the cycle it appears.
// min_span may be written while idle only.
module cubic_hermite_interpolator_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic signed [31:0] value_a,
  input  logic signed [31:0] slope_a,
  input  logic [31:0]        time_a,
  input  logic signed [31:0] value_b,
  input  logic signed [31:0] slope_b,
  input  logic [31:0]        time_b,
  input  logic [31:0]        query_time,
  output logic               done,
  output logic signed [31:0] result_value,
  output logic               degenerate_span,
  output logic               saturated
);
  import chi_pkg::*;

`include "cubic_hermite_interpolator_top_defines.svh"

  logic [15:0] min_span;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_span <= 16'd1;
    end else if (cfg_we) begin
      min_span <= cfg_wdata;
    end
  end

  assign busy = 1'b0;

  // Entry: span, its magnitude, the signed numerator of the position.
  logic signed [32:0] dt;
  logic [31:0]        adt;
  logic signed [32:0] dq;
  logic [32:0]        adq;
  chi_token_t         entry_tok;
  chi_token_t         head;

  always_comb begin
    dt = $signed({1'b0, time_b}) - $signed({1'b0, time_a});
    dq = $signed({1'b0, query_time}) - $signed({1'b0, time_a});
    adt = dt[32] ? 32'(-dt) : dt[31:0];
    adq = dq[32] ? 33'(-dq) : 33'(dq);
    entry_tok = '0;
    entry_tok.live = start;
    entry_tok.degen = (adt == 32'd0) || (adt < {16'd0, min_span});
    entry_tok.neg = dt[32] ^ dq[32];
    entry_tok.num = {adq[31:0], {FracBits{1'b0}}};
    entry_tok.den = adt;
    entry_tok.va = value_a;
    entry_tok.vb = value_b;
    entry_tok.dt = dt;
    entry_tok.s1 = slope_a;
    entry_tok.s2 = slope_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
    end else begin
      head <= entry_tok;
    end
  end

  chi_token_t chain [DivCells];

  assign chain[0] = head;

  for (genvar i = 0; i < DivCells - 1; i++) begin : g_div
    chi_div_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .in_tok (chain[i]),
      .out_tok(chain[i+1])
    );
  end

  // Position sign and clamp, then slopes scaled by the span.
  chi_token_t         last;
  logic signed [QuoBits:0] xs;
  logic signed [31:0] xq;
  logic signed [31:0] s1q;
  logic signed [31:0] s2q;
  logic               fx;
  logic               f1;
  logic               f2;
  chi_token_t         scl_tok;
  chi_token_t         scl;

  always_comb begin
    last = chain[DivCells-1];
    xs = last.neg ? -$signed({1'b0, last.quo}) : $signed({1'b0, last.quo});
    xq = sat32(64'(xs), fx);
    s1q = sat32(64'(last.s1) * 64'(last.dt), f1);
    s2q = sat32(64'(last.s2) * 64'(last.dt), f2);
    scl_tok = last;
    scl_tok.x = xq;
    scl_tok.s1 = s1q;
    scl_tok.s2 = s2q;
    scl_tok.sat = fx | f1 | f2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scl <= '0;
    end else begin
      scl <= scl_tok;
    end
  end

  logic signed [63:0] c3w;
  logic signed [63:0] c2w;
  logic               f3;
  logic               f4;
  chi_token_t         coef_tok;
  chi_token_t         coef;

  always_comb begin
    c3w = 64'sd2 * 64'(scl.va) - 64'sd2 * 64'(scl.vb) + 64'(scl.s1) + 64'(scl.s2);
    c2w = -64'sd3 * 64'(scl.va) + 64'sd3 * 64'(scl.vb) - 64'sd2 * 64'(scl.s1)
          - 64'(scl.s2);
    coef_tok = scl;
    coef_tok.c3 = sat32(c3w, f3);
    coef_tok.c2 = sat32(c2w, f4);
    coef_tok.acc = coef_tok.c3;
    coef_tok.sat = scl.sat | f3 | f4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else begin
      coef <= coef_tok;
    end
  end

  chi_token_t hrn [4];
  assign hrn[0] = coef;

  for (genvar k = 0; k < 3; k++) begin : g_hrn
    chi_horner_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .sel    (2'(k)),
      .in_tok (hrn[k]),
      .out_tok(hrn[k+1])
    );
  end

  assign done = hrn[3].live;
  assign degenerate_span = hrn[3].degen;
  assign result_value = hrn[3].degen ? hrn[3].vb : hrn[3].acc;
  assign saturated = hrn[3].degen ? 1'b0 : hrn[3].sat;

  `CHI_ASSERT_IMPL(a_degen_clean, done && degenerate_span, !saturated,
                   "degenerate item reported saturation")
  `CHI_ASSERT_IMPL(a_never_busy, 1'b1, !busy, "busy raised")
  `CHI_ASSERT_NEXT(a_head_follows, start, head.live, "started item not captured")

endmodule
